### rtl/pkrka_pkg.sv
// ----------------------------------------------------------------------------
// pkrka_pkg
// Shared types, constants and helpers for the keyword alert rule engine.
// ----------------------------------------------------------------------------
package pkrka_pkg;

  localparam int MAX_WORDS   = 4;
  localparam int WORD_BYTES  = 8;
  localparam int COUNT_BITS  = 32;
  localparam int WORD_W      = 8 * WORD_BYTES;
  localparam int LEN_W       = 4;
  localparam int THRESH_W    = 16;
  localparam int ADDR_W      = 6;
  localparam int DATA_W      = 64;

  // rule modes
  typedef enum logic [1:0] {
    MODE_ALWAYS = 2'd0,
    MODE_ALL    = 2'd1,
    MODE_ANY    = 2'd2,
    MODE_OFF    = 2'd3
  } mode_t;

  // register indexes
  typedef enum logic [2:0] {
    REG_WORD_ZERO   = 3'd0,
    REG_WORD_ONE    = 3'd1,
    REG_WORD_TWO    = 3'd2,
    REG_WORD_THREE  = 3'd3,
    REG_WORD_LENS   = 3'd4,
    REG_SRC_FILTER  = 3'd5,
    REG_DST_FILTER  = 3'd6,
    REG_THRESH_MODE = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [MAX_WORDS-1:0][WORD_W-1:0]  words;
    logic [MAX_WORDS-1:0][LEN_W-1:0]   lengths;
    logic [31:0]                       src_filter;
    logic [31:0]                       dst_filter;
    mode_t                             mode;
    logic [THRESH_W-1:0]               threshold;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_present;
    logic [31:0] packet_source;
    logic [31:0] packet_destination;
    logic        end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic                  alert;
    logic                  rule_hit;
    logic [COUNT_BITS-1:0] occurrence_count;
  } out_item_t;

  // closed packet summary handed from front to back
  typedef struct packed {
    logic [MAX_WORDS-1:0] found;
    logic                 filt_ok;
  } pkt_rec_t;

  // word length clamped to the window size
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    res = len;
    if (len > LEN_W'(WORD_BYTES)) begin
      res = LEN_W'(WORD_BYTES);
    end
    return res;
  endfunction

  // byte mask covering the low len bytes
  function automatic logic [WORD_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int j = 0; j < WORD_BYTES; j++) begin
      if (LEN_W'(j) < len) begin
        m[8*j +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

### rtl/pkrka_regs.sv
// ----------------------------------------------------------------------------
// pkrka_regs
// Configuration register file behind a 64-bit APB-style port.
// ----------------------------------------------------------------------------
module pkrka_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pkrka_pkg::ADDR_W-1:0] paddr,
  input  logic [pkrka_pkg::DATA_W-1:0] pwdata,
  output logic [pkrka_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output pkrka_pkg::cfg_t              cfg
);
  import pkrka_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_WORD_ZERO:   cfg_nxt.words[0]   = pwdata;
        REG_WORD_ONE:    cfg_nxt.words[1]   = pwdata;
        REG_WORD_TWO:    cfg_nxt.words[2]   = pwdata;
        REG_WORD_THREE:  cfg_nxt.words[3]   = pwdata;
        REG_WORD_LENS:   cfg_nxt.lengths    = pwdata[MAX_WORDS*LEN_W-1:0];
        REG_SRC_FILTER:  cfg_nxt.src_filter = pwdata[31:0];
        REG_DST_FILTER:  cfg_nxt.dst_filter = pwdata[31:0];
        REG_THRESH_MODE: begin
          cfg_nxt.threshold = pwdata[THRESH_W-1:0];
          cfg_nxt.mode      = mode_t'(pwdata[THRESH_W+1:THRESH_W]);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_WORD_ZERO:   prdata = cfg_r.words[0];
      REG_WORD_ONE:    prdata = cfg_r.words[1];
      REG_WORD_TWO:    prdata = cfg_r.words[2];
      REG_WORD_THREE:  prdata = cfg_r.words[3];
      REG_WORD_LENS:   prdata = DATA_W'(cfg_r.lengths);
      REG_SRC_FILTER:  prdata = DATA_W'(cfg_r.src_filter);
      REG_DST_FILTER:  prdata = DATA_W'(cfg_r.dst_filter);
      REG_THRESH_MODE: prdata = DATA_W'({cfg_r.mode, cfg_r.threshold});
      default:         prdata = '0;
    endcase
  end

endmodule

### rtl/pkrka_front.sv
// ----------------------------------------------------------------------------
// pkrka_front
// Byte window and keyword match; closes each packet into a summary record.
// ----------------------------------------------------------------------------
module pkrka_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pkrka_pkg::cfg_t      cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pkrka_pkg::in_item_t  in_data,
  input  logic                 q_full,
  output logic                 q_push,
  output pkrka_pkg::pkt_rec_t  q_rec
);
  import pkrka_pkg::*;

  logic [WORD_W-1:0]    window_r, window_nxt, shifted;
  logic [LEN_W-1:0]     seen_r, seen_nxt, seen_inc;
  logic [MAX_WORDS-1:0] found_r, found_nxt, found_cur, match;
  logic                 accept;
  logic [LEN_W-1:0]     len [MAX_WORDS];
  logic [LEN_W-1:0]     rem [MAX_WORDS];
  logic [WORD_W-1:0]    tail [MAX_WORDS];
  logic [WORD_W-1:0]    mask [MAX_WORDS];

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // window shifted by the incoming byte
  assign shifted  = {in_data.payload_byte, window_r[WORD_W-1:8]};
  assign seen_inc = (seen_r < LEN_W'(WORD_BYTES)) ? seen_r + 1'b1 : seen_r;

  // per-word compare against the newest bytes
  always_comb begin
    for (int i = 0; i < MAX_WORDS; i++) begin
      len[i]  = clamp_len(cfg.lengths[i]);
      rem[i]  = LEN_W'(WORD_BYTES) - len[i];
      tail[i] = shifted >> {rem[i][2:0], 3'b000};
      mask[i] = len_mask(len[i]);
      match[i] = in_data.byte_present && (len[i] != '0) && (seen_inc >= len[i]) &&
                 ((tail[i] & mask[i]) == (cfg.words[i] & mask[i]));
    end
  end

  assign found_cur = found_r | match;

  // packet state update
  always_comb begin
    window_nxt = window_r;
    seen_nxt   = seen_r;
    found_nxt  = found_r;
    if (accept) begin
      if (in_data.end_of_packet) begin
        window_nxt = '0;
        seen_nxt   = '0;
        found_nxt  = '0;
      end else if (in_data.byte_present) begin
        window_nxt = shifted;
        seen_nxt   = seen_inc;
        found_nxt  = found_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      seen_r   <= '0;
      found_r  <= '0;
    end else begin
      window_r <= window_nxt;
      seen_r   <= seen_nxt;
      found_r  <= found_nxt;
    end
  end

  // packet summary with address filters
  assign q_push        = accept && in_data.end_of_packet;
  assign q_rec.found   = found_cur;
  assign q_rec.filt_ok =
    ((cfg.src_filter == '0) || (cfg.src_filter == in_data.packet_source)) &&
    ((cfg.dst_filter == '0) || (cfg.dst_filter == in_data.packet_destination));

endmodule

### rtl/pkrka_fifo.sv
// ----------------------------------------------------------------------------
// pkrka_fifo
// Two-entry queue of packet records between front and back.
// ----------------------------------------------------------------------------
module pkrka_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pkrka_pkg::pkt_rec_t push_rec,
  output logic                full,
  input  logic                pop,
  output pkrka_pkg::pkt_rec_t pop_rec,
  output logic                empty
);
  import pkrka_pkg::*;

  pkt_rec_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign pop_rec = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("record pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("record popped from empty queue");

endmodule

### rtl/pkrka_back.sv
// ----------------------------------------------------------------------------
// pkrka_back
// Rule decision, saturating occurrence count, alert arming and result register.
// ----------------------------------------------------------------------------
module pkrka_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pkrka_pkg::cfg_t      cfg,
  input  logic                 q_empty,
  input  pkrka_pkg::pkt_rec_t  q_rec,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pkrka_pkg::out_item_t out_data
);
  import pkrka_pkg::*;

  logic [COUNT_BITS-1:0] count_r, count_nxt, count_after;
  logic                  armed_r, armed_nxt, armed_after;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;
  logic [MAX_WORDS-1:0]  used, hits;
  logic                  hit, fire;

  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  // words in use
  always_comb begin
    for (int i = 0; i < MAX_WORDS; i++) begin
      used[i] = (cfg.lengths[i] != '0);
    end
  end
  assign hits = q_rec.found & used;

  // rule decision
  always_comb begin
    hit = 1'b0;
    if (q_rec.filt_ok) begin
      unique case (cfg.mode)
        MODE_ALWAYS: hit = 1'b1;
        MODE_ALL:    hit = (used != '0) && (hits == used);
        MODE_ANY:    hit = (hits != '0);
        MODE_OFF:    hit = 1'b0;
        default:     hit = 1'b0;
      endcase
    end
  end

  // count, arming and alert
  always_comb begin
    count_after = count_r;
    if (hit && (count_r != '1)) begin
      count_after = count_r + 1'b1;
    end
    armed_after = armed_r || hit;
    fire = q_rec.filt_ok && armed_after &&
           (count_after >= COUNT_BITS'(cfg.threshold));

    count_nxt     = count_r;
    armed_nxt     = armed_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (q_pop) begin
      count_nxt     = count_after;
      armed_nxt     = armed_after && !fire;
      out_valid_nxt = 1'b1;
      out_data_nxt.alert            = fire;
      out_data_nxt.rule_hit         = hit;
      out_data_nxt.occurrence_count = count_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_alert_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && fire) |=> !armed_r) else $error("alert fired but stays armed");
  a_alert_threshold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.alert) |->
      (out_data.occurrence_count >= COUNT_BITS'(cfg.threshold)))
    else $error("alert below threshold");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && hit && (count_r != '1)) |=> (count_r == $past(count_r) + 1'b1))
    else $error("hit did not advance count");

endmodule

### rtl/packet_rule_keyword_alert_core.sv
// ----------------------------------------------------------------------------
// packet_rule_keyword_alert_core
// Keyword rule engine: byte window match in front, packet decision in back.
// ----------------------------------------------------------------------------
// a closed packet's record goes through the record queue, then the result register
// front match path takes one item per cycle while the record queue is not full
// a two-entry record queue lets the front keep going while a result waits
// reset (synchronous, rst_n low) clears registers, window, flags, count and arming
module packet_rule_keyword_alert_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pkrka_pkg::ADDR_W-1:0] paddr,
  input  logic [pkrka_pkg::DATA_W-1:0] pwdata,
  output logic [pkrka_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  pkrka_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output pkrka_pkg::out_item_t         out_data
);
  import pkrka_pkg::*;

  cfg_t     cfg;
  pkt_rec_t push_rec, pop_rec;
  logic     q_push, q_pop, q_full, q_empty;

  // configuration registers
  pkrka_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // byte window and match
  pkrka_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (push_rec)
  );

  // record queue
  pkrka_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .pop_rec  (pop_rec),
    .empty    (q_empty)
  );

  // decision and result
  pkrka_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_rec     (pop_rec),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyword alert rule engine. A short scripted
// sequence hits the corner cases, then random packets with random rule
// settings run under three stall patterns. Every packet verdict is
// predicted in the bench and compared field by field against the block.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pkrka_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 3000;
  localparam int ITEMS_PER_RULE = 110;

  typedef enum logic {ROW_CONFIG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    reg_idx_t    reg_sel;
    logic [63:0] value;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;

  // rule settings as last written
  logic [63:0] cfg_word [MAX_WORDS];
  logic [15:0] cfg_lens = '0;
  logic [31:0] cfg_src  = '0;
  logic [31:0] cfg_dst  = '0;
  logic [15:0] cfg_thr  = '0;
  mode_t       cfg_mode = MODE_ALWAYS;

  // predicted rule state
  logic [63:0] shadow_window = '0;
  int unsigned window_fill   = 0;
  bit          word_seen [MAX_WORDS];
  logic [31:0] hit_count     = '0;
  bit          alert_pending = 1'b0;

  out_item_t   verdict_q [$];
  script_row_t script [$];
  logic [7:0]  alphabet [4];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_req    = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  packet_rule_keyword_alert_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // effective length of word i, clamped to the window
  function automatic int unsigned word_size(input int i);
    int unsigned len;
    len = cfg_lens[4*i +: 4];
    if (len > WORD_BYTES) len = WORD_BYTES;
    return len;
  endfunction

  // advance the rule state by one item; returns 1 when a verdict is due
  function automatic bit predict_packet_verdict(input in_item_t it, output out_item_t verdict);
    int unsigned len;
    int unsigned used;
    int unsigned found;
    logic [63:0] tail;
    logic [63:0] mask;
    bit          hit;
    bit          fire;
    verdict = '0;
    hit = 1'b0;
    fire = 1'b0;
    used = 0;
    found = 0;
    // shift the byte in and look for each word ending here
    if (it.byte_present) begin
      shadow_window = {it.payload_byte, shadow_window[63:8]};
      if (window_fill < WORD_BYTES) window_fill++;
      for (int i = 0; i < MAX_WORDS; i++) begin
        len = word_size(i);
        if (len != 0 && window_fill >= len) begin
          mask = (len == WORD_BYTES) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
          tail = shadow_window >> (8 * (WORD_BYTES - len));
          if (((tail ^ cfg_word[i]) & mask) == '0) word_seen[i] = 1'b1;
        end
      end
    end
    if (!it.end_of_packet) return 1'b0;
    // packet decision once the filters pass
    if ((cfg_src == '0 || cfg_src == it.packet_source) &&
        (cfg_dst == '0 || cfg_dst == it.packet_destination)) begin
      for (int i = 0; i < MAX_WORDS; i++) begin
        if (word_size(i) != 0) begin
          used++;
          if (word_seen[i]) found++;
        end
      end
      case (cfg_mode)
        MODE_ALWAYS: hit = 1'b1;
        MODE_ALL:    hit = (used != 0) && (found == used);
        MODE_ANY:    hit = (found != 0);
        default:     hit = 1'b0;
      endcase
      if (hit) begin
        if (hit_count != '1) hit_count++;
        alert_pending = 1'b1;
      end
      if (alert_pending && hit_count >= {16'd0, cfg_thr}) begin
        fire = 1'b1;
        alert_pending = 1'b0;
      end
    end
    verdict.alert = fire;
    verdict.rule_hit = hit;
    verdict.occurrence_count = hit_count;
    shadow_window = '0;
    window_fill = 0;
    for (int i = 0; i < MAX_WORDS; i++) word_seen[i] = 1'b0;
    return 1'b1;
  endfunction

  // register write: setup then access phase, starting at a falling edge
  task automatic cfg_write(input reg_idx_t idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(8 * int'(idx));
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_WORD_ZERO:   cfg_word[0] = val;
      REG_WORD_ONE:    cfg_word[1] = val;
      REG_WORD_TWO:    cfg_word[2] = val;
      REG_WORD_THREE:  cfg_word[3] = val;
      REG_WORD_LENS:   cfg_lens = val[15:0];
      REG_SRC_FILTER:  cfg_src = val[31:0];
      REG_DST_FILTER:  cfg_dst = val[31:0];
      REG_THRESH_MODE: begin
        cfg_thr  = val[15:0];
        cfg_mode = mode_t'(val[17:16]);
      end
      default: ;
    endcase
  endtask

  // offer one transaction and wait for it to be taken
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t verdict;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (predict_packet_verdict(it, verdict))
      verdict_q.insert(verdict_q.size(), typed ? want : verdict);
    @(negedge clk);
  endtask

  // let all verdicts come back before touching the rule
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic add_cfg(input reg_idx_t idx, input logic [63:0] val);
    script_row_t r;
    r.kind = ROW_CONFIG;
    r.reg_sel = idx;
    r.value = val;
    r.item = '0;
    r.typed = 1'b0;
    r.want = '0;
    script.insert(script.size(), r);
  endtask

  task automatic add_item(input logic [7:0] b, input logic present, input logic [31:0] src,
                          input logic [31:0] dst, input logic last);
    script_row_t r;
    r.kind = ROW_ITEM;
    r.reg_sel = REG_WORD_ZERO;
    r.value = '0;
    r.item.payload_byte = b;
    r.item.byte_present = present;
    r.item.packet_source = src;
    r.item.packet_destination = dst;
    r.item.end_of_packet = last;
    r.typed = 1'b0;
    r.want = '0;
    script.insert(script.size(), r);
  endtask

  task automatic add_typed(input logic alert, input logic hit, input logic [31:0] count);
    script[$].typed = 1'b1;
    script[$].want.alert = alert;
    script[$].want.rule_hit = hit;
    script[$].want.occurrence_count = count;
  endtask

  function automatic logic [7:0] pick_byte();
    return ($urandom_range(99) < 80) ? alphabet[$urandom_range(3)] : 8'($urandom_range(255));
  endfunction

  // write a whole rule: style 0 all ones, 1 all zeros, else random
  task automatic load_rule(input int style);
    logic [63:0] w;
    logic [15:0] lens;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] thr;
    logic [1:0]  mode;
    int unsigned r;
    for (int i = 0; i < 4; i++) alphabet[i] = (style == 0) ? 8'hFF : 8'($urandom_range(255));
    for (int i = 0; i < MAX_WORDS; i++) begin
      if (style == 0) w = '1;
      else if (style == 1) w = '0;
      else if ($urandom_range(9) == 0) w = {$urandom, $urandom};
      else for (int j = 0; j < 8; j++) w[8*j +: 8] = pick_byte();
      cfg_write(reg_idx_t'(i), w);
    end
    for (int i = 0; i < MAX_WORDS; i++) begin
      r = $urandom_range(99);
      if (r < 15) lens[4*i +: 4] = 4'd0;
      else if (r < 80) lens[4*i +: 4] = 4'($urandom_range(1, 4));
      else if (r < 90) lens[4*i +: 4] = 4'($urandom_range(5, 8));
      else lens[4*i +: 4] = 4'($urandom_range(9, 15));
    end
    src = ($urandom_range(1) == 0) ? 32'd0 : (($urandom_range(9) == 0) ? '1 : $urandom);
    dst = ($urandom_range(1) == 0) ? 32'd0 : (($urandom_range(9) == 0) ? '1 : $urandom);
    r = $urandom_range(99);
    if (r < 40) thr = 16'($urandom_range(0, 3));
    else if (r < 70) thr = 16'($urandom_range(4, 20));
    else if (r < 90) thr = '1;
    else thr = 16'($urandom_range(65535));
    mode = ($urandom_range(9) == 0) ? MODE_OFF : 2'($urandom_range(0, 2));
    if (style == 0) begin
      lens = '1;
      src = '1;
      dst = '1;
      thr = '1;
      mode = MODE_OFF;
    end else if (style == 1) begin
      lens = '0;
      src = '0;
      dst = '0;
      thr = '0;
      mode = MODE_ALWAYS;
    end
    cfg_write(REG_WORD_LENS, {48'd0, lens});
    cfg_write(REG_SRC_FILTER, {32'd0, src});
    cfg_write(REG_DST_FILTER, {32'd0, dst});
    cfg_write(REG_THRESH_MODE, {46'd0, mode, thr});
  endtask

  // one packet, mostly well formed, with configured words planted in it
  task automatic send_random_packet(output int unsigned sent);
    logic [7:0]  body [24];
    int unsigned n;
    int unsigned len;
    int unsigned pos;
    int unsigned k;
    logic [31:0] src;
    logic [31:0] dst;
    in_item_t    it;
    n = ($urandom_range(19) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
    for (int j = 0; j < 24; j++) body[j] = pick_byte();
    repeat ($urandom_range(0, 2)) begin
      k = $urandom_range(MAX_WORDS - 1);
      len = word_size(k);
      if (len != 0 && len <= n) begin
        pos = $urandom_range(0, n - len);
        for (int t = 0; t < len; t++) body[pos + t] = cfg_word[k][8*t +: 8];
      end
    end
    src = (cfg_src != '0 && $urandom_range(99) < 70) ? cfg_src : $urandom;
    dst = (cfg_dst != '0 && $urandom_range(99) < 70) ? cfg_dst : $urandom;
    if ($urandom_range(19) == 0) src = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(19) == 0) dst = $urandom_range(1) ? '1 : '0;
    for (int j = 0; j < n; j++) begin
      it.payload_byte = body[j];
      it.byte_present = ($urandom_range(99) < 92);
      it.packet_source = src;
      it.packet_destination = dst;
      it.end_of_packet = (j == n - 1);
      // noise: a source address that wanders before the last byte
      if (j != n - 1 && $urandom_range(49) == 0) it.packet_source = $urandom;
      send_item(it, 1'b0, '0);
    end
    sent = n;
  endtask

  // result side stall, with one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // verdict checking
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (verdict_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: verdict with nothing outstanding: alert=%0b hit=%0b count=%0d",
                   $realtime, out_data.alert, out_data.rule_hit, out_data.occurrence_count);
      end else begin
        want = verdict_q.pop_front();
        if (out_data.alert !== want.alert || out_data.rule_hit !== want.rule_hit ||
            out_data.occurrence_count !== want.occurrence_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: verdict mismatch: expected alert=%0b hit=%0b count=%0d, got alert=%0b hit=%0b count=%0d",
                     $realtime, want.alert, want.rule_hit, want.occurrence_count,
                     out_data.alert, out_data.rule_hit, out_data.occurrence_count);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned items;
    int unsigned sent;
    bit          hold_done;
    rst_n    = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    in_data  = '0;
    hold_done = 1'b0;
    for (int i = 0; i < MAX_WORDS; i++) begin
      cfg_word[i] = '0;
      word_seen[i] = 1'b0;
    end

    // reset defaults: every packet hits and fires at once
    add_item(8'h00, 1'b1, 32'h0, 32'h0, 1'b1);
    add_typed(1'b1, 1'b1, 32'd1);
    add_item(8'hFF, 1'b0, '1, '1, 1'b1);
    add_typed(1'b1, 1'b1, 32'd2);

    // any-word mode; over-long lengths clamp to the window
    add_cfg(REG_WORD_ZERO, 64'h0000_0000_0063_6261);
    add_cfg(REG_WORD_ONE, '1);
    add_cfg(REG_WORD_TWO, 64'h0102_0304_0506_0708);
    add_cfg(REG_WORD_THREE, 64'h0);
    add_cfg(REG_WORD_LENS, 64'hF093);
    add_cfg(REG_SRC_FILTER, 64'h0);
    add_cfg(REG_DST_FILTER, 64'h0);
    add_cfg(REG_THRESH_MODE, {46'd0, MODE_ANY, 16'd2});
    add_item(8'h61, 1'b1, 32'h1, 32'h2, 1'b0);
    add_item(8'h62, 1'b1, 32'h1, 32'h2, 1'b0);
    add_item(8'h63, 1'b1, 32'h1, 32'h2, 1'b1);
    // word split across a packet boundary
    add_item(8'h61, 1'b1, 32'h1, 32'h2, 1'b0);
    add_item(8'h62, 1'b1, 32'h1, 32'h2, 1'b1);
    add_item(8'h63, 1'b1, 32'h1, 32'h2, 1'b1);
    // absent byte inside the word leaves the window alone
    add_item(8'h61, 1'b1, 32'h1, 32'h2, 1'b0);
    add_item(8'h00, 1'b0, 32'h1, 32'h2, 1'b0);
    add_item(8'h62, 1'b1, 32'h1, 32'h2, 1'b0);
    add_item(8'h63, 1'b1, 32'h1, 32'h2, 1'b1);

    // all-words mode with both address filters set
    add_cfg(REG_WORD_LENS, 64'h0013);
    add_cfg(REG_SRC_FILTER, 64'h1234_5678);
    add_cfg(REG_DST_FILTER, 64'hFFFF_FFFF);
    add_cfg(REG_THRESH_MODE, {46'd0, MODE_ALL, 16'hFFFF});
    add_item(8'h61, 1'b1, 32'h1234_5678, '1, 1'b0);
    add_item(8'h62, 1'b1, 32'h1234_5678, '1, 1'b0);
    add_item(8'h63, 1'b1, 32'h1234_5678, '1, 1'b0);
    add_item(8'hFF, 1'b1, 32'h1234_5678, '1, 1'b1);
    add_item(8'hFF, 1'b1, 32'h1234_5679, '1, 1'b1);
    add_item(8'hFF, 1'b1, 32'h1234_5678, 32'h0, 1'b1);
    add_item(8'hFF, 1'b1, 32'h1234_5678, '1, 1'b1);

    // no word in use, then the disabled mode, then always with open filters
    add_cfg(REG_WORD_LENS, 64'h0);
    add_cfg(REG_THRESH_MODE, {46'd0, MODE_ALL, 16'd0});
    add_item(8'h00, 1'b0, 32'h1234_5678, '1, 1'b1);
    add_cfg(REG_THRESH_MODE, {46'd0, MODE_OFF, 16'd0});
    add_item(8'h5A, 1'b1, 32'h1234_5678, '1, 1'b1);
    add_cfg(REG_SRC_FILTER, 64'h0);
    add_cfg(REG_DST_FILTER, 64'h0);
    add_cfg(REG_THRESH_MODE, {46'd0, MODE_ALWAYS, 16'hFFFF});
    add_item(8'hA5, 1'b1, 32'h0, 32'h0, 1'b1);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // scripted corner cases
    foreach (script[k]) begin
      if (script[k].kind == ROW_CONFIG) begin
        wait_drained();
        cfg_write(script[k].reg_sel, script[k].value);
      end else begin
        send_item(script[k].item, script[k].typed, script[k].want);
      end
    end

    // random packets under three stall patterns, several rules each
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 54 : 0;
      rx_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 10 : 0;
      for (int s = 0; s < 5; s++) begin
        wait_drained();
        load_rule(ph * 5 + s);
        items = 0;
        while (items < ITEMS_PER_RULE) begin
          // long result hold-off while packets keep coming
          if (ph == 0 && s == 2 && items >= 40 && !hold_done) begin
            tx_idle_pct = 0;
            hold_req = 1'b1;
            hold_done = 1'b1;
          end
          send_random_packet(sent);
          items += sent;
        end
        tx_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 54 : 0;
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pkrka_pkg.sv
rtl/pkrka_regs.sv
rtl/pkrka_front.sv
rtl/pkrka_fifo.sv
rtl/pkrka_back.sv
rtl/packet_rule_keyword_alert_core.sv
test/tb.sv
